// File: rtl/ufe_pkg.sv
// Shared types and constants for the disjoint-set union engine.
// No dependencies; imported by every other file of the block.
package ufe_pkg;

    // Fixed width of node fields on the request and result ports
    localparam int unsigned NODE_FW = 10;

    // Request codes
    localparam logic OP_FIND  = 1'b0;
    localparam logic OP_MERGE = 1'b1;

    // One request as it arrives on the command port
    typedef struct packed {
        logic               opcode;
        logic [NODE_FW-1:0] first_node;
        logic [NODE_FW-1:0] second_node;
    } t_req;

    // One result as it leaves on the result port
    typedef struct packed {
        logic [NODE_FW-1:0] root_node;
        logic               joined;
    } t_rsp;

    // Write enables from the controller to the link and size stores
    typedef struct packed {
        logic par_we;
        logic size_we;
    } t_mem_ctl;

endpackage

// File: rtl/ufe_store.sv
// Parent-link and set-size memories of the union engine, one read and one
// write port each, registered read data with write-to-read forwarding.
// Depends on ufe_pkg.
module ufe_store #(
    parameter int unsigned NODES  = 1024,
    parameter int unsigned NODE_W = 10,
    parameter int unsigned SIZE_W = 11
) (
    input  logic                i_clk,
    input  ufe_pkg::t_mem_ctl   i_ctl,
    input  logic [NODE_W-1:0]   i_par_raddr,
    input  logic [NODE_W-1:0]   i_par_waddr,
    input  logic [NODE_W-1:0]   i_par_wdata,
    output logic [NODE_W-1:0]   o_par_rdata,
    input  logic [NODE_W-1:0]   i_size_raddr,
    input  logic [NODE_W-1:0]   i_size_waddr,
    input  logic [SIZE_W-1:0]   i_size_wdata,
    output logic [SIZE_W-1:0]   o_size_rdata
);
    import ufe_pkg::*;

    logic [NODE_W-1:0] r_par_mem  [NODES];
    logic [SIZE_W-1:0] r_size_mem [NODES];
    logic [NODE_W-1:0] r_par_rdata;
    logic [SIZE_W-1:0] r_size_rdata;

    // Parent links: forward a same-cycle write to the read port
    always_ff @(posedge i_clk) begin
        if (i_ctl.par_we) begin
            r_par_mem[i_par_waddr] <= i_par_wdata;
        end
        if (i_ctl.par_we && (i_par_waddr == i_par_raddr)) begin
            r_par_rdata <= i_par_wdata;
        end else begin
            r_par_rdata <= r_par_mem[i_par_raddr];
        end
    end

    // Set sizes: same arrangement
    always_ff @(posedge i_clk) begin
        if (i_ctl.size_we) begin
            r_size_mem[i_size_waddr] <= i_size_wdata;
        end
        if (i_ctl.size_we && (i_size_waddr == i_size_raddr)) begin
            r_size_rdata <= i_size_wdata;
        end else begin
            r_size_rdata <= r_size_mem[i_size_raddr];
        end
    end

    assign o_par_rdata  = r_par_rdata;
    assign o_size_rdata = r_size_rdata;

endmodule

// File: rtl/union_find_engine_unit.sv
// Top level of the disjoint-set union engine: request decode, walk and
// compression sequencer, union by size. Depends on ufe_pkg and ufe_store.
//
// Usage:
//   Command port: a request (i_req: opcode, first_node, second_node) is
//   taken at a rising edge with start high and busy low. opcode FIND
//   returns the root of first_node; MERGE joins the sets of both nodes
//   and returns the surviving root, with joined set when two sets met.
//   Result port: o_done is high for exactly one cycle with o_rsp valid.
//   The receiver cannot stall; each request gives exactly one result.
//   Timing: one request at a time. A find walks from its node up to the
//   root in S_WALK, then re-points each node of the path at the root in
//   S_CMP (one parent-memory access per cycle). A merge is two such finds
//   back to back; when the roots differ it adds a size-read state and a
//   join state. The result strobe o_done is registered.
//   Compression keeps most paths short, so the walk is data dependent.
//   busy drops in the cycle o_done shows, so the next request can be
//   taken at the edge that ends the result cycle.
//   Reset (i_rst_n low, synchronous): a clearing pass follows, writing
//   every node as its own root of size one; busy stays high until it
//   ends.
module union_find_engine_unit #(
    parameter int unsigned NODES = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  ufe_pkg::t_req i_req,
    output logic          busy,
    output logic          o_done,
    output ufe_pkg::t_rsp o_rsp
);
    import ufe_pkg::*;

    localparam int unsigned NODE_W = $clog2(NODES);
    localparam int unsigned SIZE_W = $clog2(NODES + 1);
    localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODES - 1);

    // Sequencer states
    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_WALK = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_SZB  = 3'd4;
    localparam logic [2:0] S_JOIN = 3'd5;

    // Saturate a port node index onto the node range
    function automatic logic [NODE_W-1:0] clamp_node(input logic [NODE_FW-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        if (w >= 32'(NODES)) begin
            w = 32'(NODES - 1);
        end
        return w[NODE_W-1:0];
    endfunction

    // Widen or narrow an internal node index to the port width
    function automatic logic [NODE_FW-1:0] port_node(input logic [NODE_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[NODE_FW-1:0];
    endfunction

    logic [2:0]        r_state, n_state;
    logic [NODE_W-1:0] r_clr_idx, n_clr_idx;
    logic              r_op, n_op;
    logic              r_second, n_second;
    logic [NODE_W-1:0] r_b, n_b;
    logic [NODE_W-1:0] r_start, n_start;
    logic [NODE_W-1:0] r_cur, n_cur;
    logic [NODE_W-1:0] r_root, n_root;
    logic [NODE_W-1:0] r_ra, n_ra;
    logic [NODE_W-1:0] r_rb, n_rb;
    logic [SIZE_W-1:0] r_sa, n_sa;
    logic              r_done, n_done;
    t_rsp              r_rsp, n_rsp;

    t_mem_ctl          mem_ctl;
    logic [NODE_W-1:0] par_raddr, par_waddr, par_wdata, par_rdata;
    logic [NODE_W-1:0] size_raddr, size_waddr;
    logic [SIZE_W-1:0] size_wdata, size_rdata;

    logic              find_done;
    logic [NODE_W-1:0] found_root;
    logic [NODE_W-1:0] first_in;
    logic [NODE_W-1:0] winner, loser;

    ufe_store #(
        .NODES  (NODES),
        .NODE_W (NODE_W),
        .SIZE_W (SIZE_W)
    ) u_store (
        .i_clk        (i_clk),
        .i_ctl        (mem_ctl),
        .i_par_raddr  (par_raddr),
        .i_par_waddr  (par_waddr),
        .i_par_wdata  (par_wdata),
        .o_par_rdata  (par_rdata),
        .i_size_raddr (size_raddr),
        .i_size_waddr (size_waddr),
        .i_size_wdata (size_wdata),
        .o_size_rdata (size_rdata)
    );

    assign first_in = clamp_node(i_req.first_node);

    // Sequencer: walk, compress, size and join
    always_comb begin
        n_state    = r_state;
        n_clr_idx  = r_clr_idx;
        n_op       = r_op;
        n_second   = r_second;
        n_b        = r_b;
        n_start    = r_start;
        n_cur      = r_cur;
        n_root     = r_root;
        n_ra       = r_ra;
        n_rb       = r_rb;
        n_sa       = r_sa;
        n_done     = 1'b0;
        n_rsp      = r_rsp;
        mem_ctl    = '0;
        par_raddr  = r_cur;
        par_waddr  = r_cur;
        par_wdata  = r_root;
        size_raddr = r_ra;
        size_waddr = r_ra;
        size_wdata = SIZE_W'(1);
        find_done  = 1'b0;
        found_root = r_root;
        winner     = r_ra;
        loser      = r_rb;

        unique case (r_state)
            S_CLR: begin
                // Sweep every entry back to a singleton set
                mem_ctl.par_we  = 1'b1;
                mem_ctl.size_we = 1'b1;
                par_waddr       = r_clr_idx;
                par_wdata       = r_clr_idx;
                size_waddr      = r_clr_idx;
                n_clr_idx       = r_clr_idx + NODE_W'(1);
                if (r_clr_idx == LAST_NODE) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                // Take a request and start the walk from the first node
                if (start) begin
                    n_op      = i_req.opcode;
                    n_b       = clamp_node(i_req.second_node);
                    n_second  = 1'b0;
                    n_start   = first_in;
                    n_cur     = first_in;
                    par_raddr = first_in;
                    n_state   = S_WALK;
                end
            end
            S_WALK: begin
                // Follow one link a cycle until a self-link shows the root
                if (par_rdata == r_cur) begin
                    found_root = r_cur;
                    n_root     = r_cur;
                    if (r_start == r_cur) begin
                        find_done = 1'b1;
                    end else begin
                        n_cur     = r_start;
                        par_raddr = r_start;
                        n_state   = S_CMP;
                    end
                end else begin
                    n_cur     = par_rdata;
                    par_raddr = par_rdata;
                end
            end
            S_CMP: begin
                // Re-point the current node at the root, advance along the path
                mem_ctl.par_we = 1'b1;
                if (par_rdata == r_root) begin
                    find_done = 1'b1;
                end else begin
                    n_cur     = par_rdata;
                    par_raddr = par_rdata;
                end
            end
            S_SZB: begin
                // Hold the first root's size, fetch the second
                n_sa       = size_rdata;
                size_raddr = r_rb;
                n_state    = S_JOIN;
            end
            S_JOIN: begin
                // Hang the smaller set under the larger; a tie keeps the first root
                if (r_sa < size_rdata) begin
                    winner = r_rb;
                    loser  = r_ra;
                end
                mem_ctl.par_we  = 1'b1;
                mem_ctl.size_we = 1'b1;
                par_waddr       = loser;
                par_wdata       = winner;
                size_waddr      = winner;
                size_wdata      = r_sa + size_rdata;
                n_done          = 1'b1;
                n_rsp.root_node = port_node(winner);
                n_rsp.joined    = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // End of a find: chain to the second find, report, or go to sizing
        if (find_done) begin
            priority if (!r_second && (r_op == OP_MERGE)) begin
                n_ra      = found_root;
                n_second  = 1'b1;
                n_start   = r_b;
                n_cur     = r_b;
                par_raddr = r_b;
                n_state   = S_WALK;
            end else if (!r_second) begin
                n_done          = 1'b1;
                n_rsp.root_node = port_node(found_root);
                n_rsp.joined    = 1'b0;
                n_state         = S_IDLE;
            end else if (found_root == r_ra) begin
                n_done          = 1'b1;
                n_rsp.root_node = port_node(r_ra);
                n_rsp.joined    = 1'b0;
                n_state         = S_IDLE;
            end else begin
                n_rb       = found_root;
                size_raddr = r_ra;
                n_state    = S_SZB;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr_idx <= '0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
            r_done    <= n_done;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_second <= n_second;
        r_b      <= n_b;
        r_start  <= n_start;
        r_cur    <= n_cur;
        r_root   <= n_root;
        r_ra     <= n_ra;
        r_rb     <= n_rb;
        r_sa     <= n_sa;
        r_rsp    <= n_rsp;
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

// File: rtl/ufe_checker.sv
// Port-level checks for union_find_engine_unit, attached by bind.
// Depends on ufe_pkg.
module ufe_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input ufe_pkg::t_req i_req,
    input logic          busy,
    input logic          o_done,
    input ufe_pkg::t_rsp o_rsp
);
    import ufe_pkg::*;

    // A result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    // An accepted request keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted without going busy");

    // A result shows only as the block turns idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (!busy && $past(busy)))
        else $error("result strobe without a request in progress");

    // An accepted request carries defined fields
    a_req_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> !$isunknown(i_req))
        else $error("request accepted with undefined fields");

    // A result carries defined fields
    a_rsp_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !$isunknown(o_rsp))
        else $error("result strobe with undefined fields");

endmodule

bind union_find_engine_unit ufe_checker u_ufe_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .i_req   (i_req),
    .busy    (busy),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);

// File: dv/testbench.sv
// Self-checking testbench for union_find_engine_unit (disjoint-set union engine).
// Depends on ufe_pkg for the request and result types and the opcode names.
// A local union-by-size model with path compression predicts every result.
module testbench;
    import ufe_pkg::*;

    localparam int unsigned NODE_COUNT  = 1024;
    localparam int unsigned RAND_ITEMS  = 1850;
    localparam int unsigned CALM_TAIL   = 200;
    localparam int unsigned DRAIN_WAIT  = 64;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned SHOW_FAULTS = 10;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req i_req   = '0;
    logic busy;
    logic o_done;
    t_rsp o_rsp;

    // Model state of the forest
    logic [NODE_FW-1:0] link_tbl [NODE_COUNT];
    logic [10:0]        size_tbl [NODE_COUNT];

    t_req req_backlog_q [$];
    t_rsp root_answers_q [$];

    int unsigned total_reqs;
    int unsigned accepted_cnt;
    int unsigned gap_left;
    int unsigned cycle_cnt;
    int unsigned result_cnt;
    int unsigned fault_cnt;
    int unsigned n_find;
    int unsigned n_joined;
    int unsigned n_same_set;
    int unsigned deepest_walk;

    union_find_engine_unit #(
        .NODES(NODE_COUNT)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .i_req  (i_req),
        .busy   (busy),
        .o_done (o_done),
        .o_rsp  (o_rsp)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Walk to the root, then re-point every node on the path at it
    function automatic logic [NODE_FW-1:0] root_with_flatten(input logic [NODE_FW-1:0] node);
        logic [NODE_FW-1:0] root;
        logic [NODE_FW-1:0] cur;
        logic [NODE_FW-1:0] nxt;
        int unsigned        steps;
        root  = node;
        steps = 0;
        while (link_tbl[root] != root && steps < NODE_COUNT) begin
            root = link_tbl[root];
            steps++;
        end
        if (steps > deepest_walk) begin
            deepest_walk = steps;
        end
        cur   = node;
        steps = 0;
        while (cur != root && steps < NODE_COUNT) begin
            nxt           = link_tbl[cur];
            link_tbl[cur] = root;
            cur           = nxt;
            steps++;
        end
        return root;
    endfunction

    // Apply one request to the model forest and return its result
    function automatic t_rsp union_outcome(input t_req r);
        logic [NODE_FW-1:0] ra;
        logic [NODE_FW-1:0] rb;
        logic [NODE_FW-1:0] tmp;
        logic [NODE_FW-1:0] a;
        logic [NODE_FW-1:0] b;
        t_rsp               rsp;
        // Saturate indexes beyond the node count
        a = (int'(r.first_node) >= NODE_COUNT) ? NODE_FW'(NODE_COUNT - 1) : r.first_node;
        b = (int'(r.second_node) >= NODE_COUNT) ? NODE_FW'(NODE_COUNT - 1) : r.second_node;
        rsp.joined = 1'b0;
        ra = root_with_flatten(a);
        if (r.opcode == OP_MERGE) begin
            rb = root_with_flatten(b);
            if (ra != rb) begin
                // Smaller set goes under the larger; a tie keeps the first root
                if (size_tbl[ra] < size_tbl[rb]) begin
                    tmp = ra;
                    ra  = rb;
                    rb  = tmp;
                end
                link_tbl[rb] = ra;
                size_tbl[ra] = size_tbl[ra] + size_tbl[rb];
                rsp.joined   = 1'b1;
                n_joined++;
            end else begin
                n_same_set++;
            end
        end else begin
            n_find++;
        end
        rsp.root_node = ra;
        return rsp;
    endfunction

    function automatic void note_fault(input string msg);
        fault_cnt++;
        if (fault_cnt <= SHOW_FAULTS) begin
            $display("[%0d] %s", cycle_cnt, msg);
        end
    endfunction

    task automatic add_req(input logic op, input int unsigned a, input int unsigned b);
        t_req r;
        r.opcode      = op;
        r.first_node  = NODE_FW'(a);
        r.second_node = NODE_FW'(b);
        req_backlog_q.push_back(r);
    endtask

    // Driver: hand over the front request, with random idle bursts
    always @(posedge i_clk) begin : drive_reqs
        logic go;
        logic take;
        go = 1'b0;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            take = start && !busy;
            if (take) begin
                root_answers_q.push_back(union_outcome(req_backlog_q.pop_front()));
                accepted_cnt++;
            end
            if (gap_left > 0) begin
                gap_left--;
            end else if (req_backlog_q.size() == 0) begin
                go = 1'b0;
            end else if ((take || !start) && accepted_cnt + CALM_TAIL < total_reqs
                         && $urandom_range(0, 5) == 0) begin
                // Start an idle burst of random length
                gap_left = $urandom_range(0, 6);
            end else begin
                go = 1'b1;
            end
            start <= go;
            if (go) begin
                i_req <= req_backlog_q[0];
            end
        end
    end

    // Monitor: check each result against the oldest prediction
    always @(posedge i_clk) begin : check_rsps
        t_rsp want;
        if (i_rst_n && o_done) begin
            result_cnt++;
            if (root_answers_q.size() == 0) begin
                note_fault($sformatf("unexpected result root=%0d joined=%0b",
                                     o_rsp.root_node, o_rsp.joined));
            end else begin
                want = root_answers_q.pop_front();
                if (o_rsp.root_node !== want.root_node) begin
                    note_fault($sformatf("root_node mismatch: expected %0d, got %0d",
                                         want.root_node, o_rsp.root_node));
                end
                if (o_rsp.joined !== want.joined) begin
                    note_fault($sformatf("joined mismatch: expected %0b, got %0b",
                                         want.joined, o_rsp.joined));
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d requests queued, %0d results owed",
                     cycle_cnt, req_backlog_q.size(), root_answers_q.size());
            $display("simulation failed");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned sel;
        int unsigned win_base;
        for (int i = 0; i < NODE_COUNT; i++) begin
            link_tbl[i] = NODE_FW'(i);
            size_tbl[i] = 11'd1;
        end

        // Directed: extremes, same-set merges, ties, deep chains, compression
        add_req(OP_FIND,  0, 1023);
        add_req(OP_FIND,  1023, 0);
        add_req(OP_MERGE, 0, 1023);
        add_req(OP_MERGE, 1023, 0);
        add_req(OP_MERGE, 5, 5);
        add_req(OP_MERGE, 2, 3);
        add_req(OP_MERGE, 4, 5);
        add_req(OP_MERGE, 3, 5);
        add_req(OP_MERGE, 6, 2);
        add_req(OP_MERGE, 7, 8);
        add_req(OP_MERGE, 9, 10);
        add_req(OP_MERGE, 7, 9);
        add_req(OP_MERGE, 11, 12);
        add_req(OP_MERGE, 13, 14);
        add_req(OP_MERGE, 11, 13);
        add_req(OP_MERGE, 7, 11);
        add_req(OP_FIND,  14, 1023);
        add_req(OP_FIND,  14, 682);
        add_req(OP_MERGE, 2, 7);
        add_req(OP_FIND,  1023, 341);
        add_req(OP_MERGE, 512, 511);
        add_req(OP_FIND,  341, 682);
        add_req(OP_MERGE, 682, 341);
        add_req(OP_FIND,  10, 0);

        // Random: merges and finds, part of them inside a small window
        // so that sets grow deep before paths are flattened
        win_base = $urandom_range(0, NODE_COUNT - 16);
        for (int i = 0; i < RAND_ITEMS; i++) begin
            if (i % 32 == 0) begin
                win_base = $urandom_range(0, NODE_COUNT - 16);
            end
            sel = $urandom_range(0, 99);
            if (sel < 40) begin
                add_req(OP_MERGE, $urandom_range(0, 1023), $urandom_range(0, 1023));
            end else if (sel < 60) begin
                add_req(OP_MERGE, win_base + $urandom_range(0, 15),
                        win_base + $urandom_range(0, 15));
            end else if (sel < 85) begin
                add_req(OP_FIND, $urandom_range(0, 1023), $urandom_range(0, 1023));
            end else begin
                add_req(OP_FIND, win_base + $urandom_range(0, 15), $urandom_range(0, 1023));
            end
        end
        total_reqs = req_backlog_q.size();

        // Hold reset, then release it once
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every request to go in and every result to come back
        while (req_backlog_q.size() != 0 || start) @(posedge i_clk);
        while (root_answers_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Covered %0d requests: %0d finds, %0d joining merges, %0d same-set merges",
                 accepted_cnt, n_find, n_joined, n_same_set);
        $display("Checked %0d results; longest walk %0d links, %0d faults",
                 result_cnt, deepest_walk, fault_cnt);
        if (fault_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
